// ===== sv/fully_associative_lru_tag_cache_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fully associative LRU tag cache
// Clocked property check with synchronous reset disable; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FULLY_ASSOCIATIVE_LRU_TAG_CACHE_CORE_ASSERT_SVH
`define FULLY_ASSOCIATIVE_LRU_TAG_CACHE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FALRU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FALRU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FALRU_ASSERT(lbl, clk, rst_n, prop, msg)
`define FALRU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/falru_pkg.sv =====
// ----------------------------------------------------------------------------
// falru_pkg
// Shared constants, command codes and controller states of the tag cache.
// ----------------------------------------------------------------------------
package falru_pkg;

    localparam int ENTRIES_DEF    = 512;
    localparam int LINE_BYTES_DEF = 4096;

    localparam int SEED_W     = 64;
    localparam int ADDR_W     = 64;
    localparam int STAMP_W    = 64;
    localparam int LINE_MAX_W = 52;
    localparam int IDX_OUT_W  = 9;
    localparam int CNT_W      = 32;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

// ===== sv/falru_tag_ram.sv =====
// ----------------------------------------------------------------------------
// falru_tag_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module falru_tag_ram #(
    parameter int ENTRIES = falru_pkg::ENTRIES_DEF,
    parameter int WORD_W  = 2 * falru_pkg::STAMP_W + falru_pkg::LINE_MAX_W
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  logic [WORD_W-1:0]          i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output logic [WORD_W-1:0]          o_rdata
);
    import falru_pkg::*;

    logic [WORD_W-1:0] r_mem [ENTRIES];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fully_associative_lru_tag_cache_core.sv =====
// ----------------------------------------------------------------------------
// fully_associative_lru_tag_cache_core
// Fully associative tag store with timestamp LRU replacement and hit/miss
// counters. A command is taken when start is high and busy is low. A clear
// command returns its all-zero result on the next cycle. An access scans the
// valid entries through the single read port of the entry memory, one entry
// per cycle, then writes the hit, free or victim entry back: busy stays high
// through the scan, a drain state and the write state (only the write state
// when no entry is valid), and the result is on the output ports for one
// cycle, marked by o_strobe, in the first cycle with busy low. The
// receiver cannot stall; every result must be taken in the cycle it is
// shown. Valid entries always form a prefix
// tracked by a fill count, so no clearing pass is needed after reset or
// clear. LINE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
`include "fully_associative_lru_tag_cache_core_assert.svh"

module fully_associative_lru_tag_cache_core #(
    parameter int ENTRIES    = falru_pkg::ENTRIES_DEF,
    parameter int LINE_BYTES = falru_pkg::LINE_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_command,
    input  logic [falru_pkg::SEED_W-1:0]    i_seed_tag,
    input  logic [falru_pkg::ADDR_W-1:0]    i_byte_address,
    output logic                            o_strobe,
    output logic                            o_hit,
    output logic [falru_pkg::IDX_OUT_W-1:0] o_slot_index,
    output logic [falru_pkg::CNT_W-1:0]     o_hit_count,
    output logic [falru_pkg::CNT_W-1:0]     o_miss_count
);
    import falru_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int LINE_W = (ADDR_W - OFF_W > LINE_MAX_W) ? LINE_MAX_W : ADDR_W - OFF_W;
    localparam int WORD_W = SEED_W + LINE_W + STAMP_W;

    t_state r_state;
    t_state n_state;

    logic scan_rd;
    logic do_write;
    logic accept;
    logic accept_access;
    logic accept_clear;
    logic scan_last;

    logic [SEED_W-1:0]  r_seed;
    logic [LINE_W-1:0]  r_line;
    logic [STAMP_W-1:0] r_clock;
    logic [FILL_W-1:0]  r_fill;
    logic [CNT_W-1:0]   r_hits;
    logic [CNT_W-1:0]   r_misses;
    logic [IDX_W-1:0]   r_addr;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [STAMP_W-1:0] r_min_stamp;
    logic [IDX_W-1:0]   r_min_idx;

    logic                 r_strobe;
    logic                 r_hit;
    logic [IDX_OUT_W-1:0] r_index;

    logic [ADDR_W-1:0]          addr_shift;
    logic [WORD_W-1:0]          rdata;
    logic [SEED_W-1:0]          rd_seed;
    logic [LINE_W-1:0]          rd_line;
    logic [STAMP_W-1:0]         rd_stamp;
    logic                       tag_match;
    logic                       not_full;
    logic [IDX_W-1:0]           slot;
    logic [IDX_W+IDX_OUT_W-1:0] slot_ext;
    logic [FILL_W-1:0]          addr_ext;

    assign accept        = start && !busy;
    assign accept_access = accept && (i_command == CMD_ACCESS);
    assign accept_clear  = accept && (i_command == CMD_CLEAR);

    assign addr_shift = i_byte_address >> OFF_W;
    assign addr_ext   = FILL_W'(r_addr);
    assign scan_last  = (addr_ext + FILL_W'(1)) == r_fill;
    assign not_full   = r_fill != FILL_W'(ENTRIES);

    assign rd_stamp  = rdata[STAMP_W-1:0];
    assign rd_line   = rdata[STAMP_W +: LINE_W];
    assign rd_seed   = rdata[STAMP_W+LINE_W +: SEED_W];
    assign tag_match = (rd_seed == r_seed) && (rd_line == r_line);

    always_comb begin
        if (r_found) begin
            slot = r_hit_idx;
        end else if (not_full) begin
            slot = r_fill[IDX_W-1:0];
        end else begin
            slot = r_min_idx;
        end
    end

    assign slot_ext = {{IDX_OUT_W{1'b0}}, slot};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept_access) begin
                    n_state = (r_fill == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_FINISH;
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy     = 1'b1;
        scan_rd  = 1'b0;
        do_write = 1'b0;
        case (r_state)
            ST_IDLE:   busy     = 1'b0;
            ST_SCAN:   scan_rd  = 1'b1;
            ST_DRAIN:  busy     = 1'b1;
            ST_FINISH: do_write = 1'b1;
            default:   busy     = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture seed tag and line address of an access command
    always_ff @(posedge i_clk) begin
        if (accept_access) begin
            r_seed <= i_seed_tag;
            r_line <= addr_shift[LINE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock  <= '0;
            r_fill   <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else if (accept_clear) begin
            r_clock  <= '0;
            r_fill   <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else if (accept_access) begin
            r_clock <= r_clock + STAMP_W'(1);
        end else if (do_write) begin
            if (r_found) begin
                r_hits <= (r_hits == '1) ? r_hits : r_hits + CNT_W'(1);
            end else begin
                r_misses <= (r_misses == '1) ? r_misses : r_misses + CNT_W'(1);
                if (not_full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    // scan address and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= scan_rd;
            if (accept_access) begin
                r_addr <= '0;
            end else if (scan_rd) begin
                r_addr <= r_addr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (accept_access) begin
            r_found <= 1'b0;
        end else if (r_rd_vld && tag_match && !r_found) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (tag_match && !r_found) begin
                r_hit_idx <= r_rd_idx;
            end
            if ((r_rd_idx == '0) || (rd_stamp < r_min_stamp)) begin
                r_min_stamp <= rd_stamp;
                r_min_idx   <= r_rd_idx;
            end
        end
    end

    falru_tag_ram #(
        .ENTRIES (ENTRIES),
        .WORD_W  (WORD_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (slot),
        .i_wdata ({r_seed, r_line, r_clock}),
        .i_re    (scan_rd),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept_clear || do_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_clear) begin
            r_hit   <= 1'b0;
            r_index <= '0;
        end else if (do_write) begin
            r_hit   <= r_found;
            r_index <= slot_ext[IDX_OUT_W-1:0];
        end
    end

    assign o_strobe      = r_strobe;
    assign o_hit         = r_hit;
    assign o_slot_index  = r_index;
    assign o_hit_count   = r_hits;
    assign o_miss_count  = r_misses;

    `FALRU_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(ENTRIES), "fill count above depth")
    `FALRU_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_strobe, "result after reset")
    `FALRU_ASSERT(a_strobe_source, i_clk, i_rst_n, r_strobe |-> ($past(r_state == ST_FINISH) || $past(start && !busy && i_command == CMD_CLEAR)), "result without finished command")
    `FALRU_ASSERT(a_hit_in_fill, i_clk, i_rst_n, (do_write && r_found) |-> (FILL_W'(r_hit_idx) < r_fill), "hit on entry beyond fill count")
    `FALRU_ASSERT(a_read_in_scan, i_clk, i_rst_n, r_rd_vld |-> (r_state == ST_DRAIN || r_state == ST_SCAN), "read data outside scan")

endmodule
